// ===== design/ntc_voltage_to_temperature_core_assert.svh =====
// ----------------------------------------------------------------------------
// NTC converter assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NTC_VOLTAGE_TO_TEMPERATURE_CORE_ASSERT_SVH
`define NTC_VOLTAGE_TO_TEMPERATURE_CORE_ASSERT_SVH

// same-cycle implication
`define NTC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ntcv2t_pkg.sv =====
// ----------------------------------------------------------------------------
// NTC converter package
// Widths, constants, band tables and shared types.
// ----------------------------------------------------------------------------
package ntcv2t_pkg;

    localparam int unsigned V_W     = 16;
    localparam int unsigned CODE_W  = 15;
    localparam int unsigned NUM_W   = 34;
    localparam int unsigned DEN_W   = 13;
    localparam int unsigned R_W     = 34;
    localparam int unsigned DIVN_W  = 52;
    localparam int unsigned LOG_W   = 40;
    localparam int unsigned MAG_W   = 34;
    localparam int unsigned TP_W    = 51;
    localparam int unsigned TM_W    = 48;
    localparam int unsigned OFS_W   = 49;
    localparam int unsigned Q_DEPTH = 2;

    localparam logic [V_W-1:0]    FULL_MV  = 16'd5000;
    localparam logic [13:0]       R_BASE   = 14'd10000;
    localparam logic [R_W-1:0]    R_COLD   = 34'(193278) << 8;
    localparam logic [CODE_W-1:0] CODE_MAX = 15'd20000;
    localparam logic [27:0]       LN2_Q28  = 28'd186065279;
    localparam logic [16:0]       T_SCALE  = 17'd100000;
    localparam logic [OFS_W-1:0]  OFS_Q28  = 49'(4000) << 28;

    typedef enum logic [1:0] {
        K_NORMAL,
        K_ZERO,
        K_FULL
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVN_W-1:0] quotient;
    } t_div_rsp;

    // elaboration-time log2 in Q32
    function automatic longint log2_q32(input longint unsigned x);
        int              p;
        longint unsigned m;
        longint unsigned frac;
        p    = 63;
        frac = 0;
        while (p > 0 && ((x >> p) & 64'd1) == 64'd0)
            p--;
        if (p >= 31)
            m = x >> (p - 31);
        else
            m = x << (31 - p);
        for (int i = 31; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m    = m >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        return longint'(p) * 64'sh1_0000_0000 + longint'(frac);
    endfunction

    localparam logic [LOG_W-1:0] LA0 = LOG_W'(log2_q32(64'(25157) << 8));
    localparam logic [LOG_W-1:0] LA1 = LOG_W'(log2_q32(64'(27509) << 8));
    localparam logic [LOG_W-1:0] LA2 = LOG_W'(log2_q32(64'(26583) << 8));
    localparam logic [LOG_W-1:0] LA3 = LOG_W'(log2_q32(64'(23608) << 8));
    localparam logic [LOG_W-1:0] LA4 = LOG_W'(log2_q32(64'(20598) << 8));
    localparam logic [LOG_W-1:0] LA5 = LOG_W'(log2_q32(64'(15818) << 8));
    localparam logic [LOG_W-1:0] LA6 = LOG_W'(log2_q32(64'(13137) << 8));

    function automatic logic [R_W-1:0] band_low(input logic [2:0] b);
        case (b)
            3'd0:    return 34'(53752) << 8;
            3'd1:    return 34'(21196) << 8;
            3'd2:    return 34'(8305) << 8;
            3'd3:    return 34'(4902) << 8;
            3'd4:    return 34'(2512) << 8;
            3'd5:    return 34'(1534) << 8;
            default: return '0;
        endcase
    endfunction

    function automatic logic [LOG_W-1:0] band_la(input logic [2:0] b);
        case (b)
            3'd0:    return LA0;
            3'd1:    return LA1;
            3'd2:    return LA2;
            3'd3:    return LA3;
            3'd4:    return LA4;
            3'd5:    return LA5;
            default: return LA6;
        endcase
    endfunction

    function automatic logic [DEN_W-1:0] band_k(input logic [2:0] b);
        case (b)
            3'd0:    return 13'd50;
            3'd1:    return 13'd44;
            3'd2:    return 13'd39;
            3'd3:    return 13'd35;
            3'd4:    return 13'd32;
            3'd5:    return 13'd28;
            default: return 13'd26;
        endcase
    endfunction

    function automatic logic [2:0] band_of(input logic [R_W-1:0] r);
        logic [2:0] b;
        b = 3'd6;
        for (int i = 5; i >= 0; i--) begin
            if (r >= band_low(3'(i)))
                b = 3'(i);
        end
        return b;
    endfunction

endpackage

// ===== design/ntcv2t_if.sv =====
// ----------------------------------------------------------------------------
// NTC converter channels
// Valid/ready channels for voltage items and temperature code items.
// ----------------------------------------------------------------------------
interface ntcv2t_in_if import ntcv2t_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [V_W-1:0] voltage_mv;
    modport source (output valid, output voltage_mv, input ready);
    modport sink (input valid, input voltage_mv, output ready);
endinterface

interface ntcv2t_out_if import ntcv2t_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] temp_code;
    modport source (output valid, output temp_code, input ready);
    modport sink (input valid, input temp_code, output ready);
endinterface

// ===== design/ntcv2t_front.sv =====
// ----------------------------------------------------------------------------
// NTC converter front end
// Classifies each item (zero, full scale, normal), forms the divider numerator/denominator.
// ----------------------------------------------------------------------------
module ntcv2t_front import ntcv2t_pkg::*; (
    ntcv2t_in_if.sink i_in,
    input  logic      i_q_ready,
    output logic      o_push,
    output t_item     o_item
);

    logic [12:0] v13;
    logic [26:0] prod;

    assign v13  = i_in.voltage_mv[12:0];
    assign prod = 27'(R_BASE) * 27'(v13);

    always_comb begin
        o_item.num  = {prod[25:0], 8'd0};
        o_item.den  = 13'(FULL_MV) - v13;
        if (i_in.voltage_mv == '0)
            o_item.kind = K_ZERO;
        else if (i_in.voltage_mv >= FULL_MV)
            o_item.kind = K_FULL;
        else
            o_item.kind = K_NORMAL;
    end

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

endmodule

// ===== design/ntcv2t_fifo.sv =====
// ----------------------------------------------------------------------------
// NTC converter item queue
// Short register queue between front and back end.
// ----------------------------------------------------------------------------
module ntcv2t_fifo import ntcv2t_pkg::*; #(
    parameter int unsigned DEPTH = Q_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    output logic      o_ready,
    input  logic      i_pop,
    output logic      o_valid,
    output t_item     o_item,
    output t_q_status o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_ready        = !o_status.full;
    assign o_valid        = !o_status.empty;
    assign o_item         = r_mem[r_rd];
    assign do_push        = i_push && o_ready;
    assign do_pop         = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_item;
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push)
                r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== design/ntcv2t_div.sv =====
// ----------------------------------------------------------------------------
// NTC converter divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntcv2t_div import ntcv2t_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(DIVN_W + 1);

    logic [DIVN_W-1:0] r_quo;
    logic [DEN_W:0]    r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    rem_sh;
    logic              q_bit;

    assign rem_sh = {r_rem[DEN_W-1:0], r_quo[DIVN_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_quo <= {r_quo[DIVN_W-2:0], q_bit};
                r_rem <= q_bit ? rem_sh - {1'b0, r_den} : rem_sh;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_cnt  <= CNT_W'(DIVN_W);
                r_busy <= 1'b1;
            end
        end
    end

endmodule

// ===== design/ntcv2t_back.sv =====
// ----------------------------------------------------------------------------
// NTC converter back end
// Sequencer: resistance divide, log2 by squaring, scaling, clamp, output.
// ----------------------------------------------------------------------------
module ntcv2t_back import ntcv2t_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_q_pop,
    output t_div_req          o_div_req,
    input  t_div_rsp          i_div_rsp,
    output logic              o_valid,
    output logic [CODE_W-1:0] o_code,
    input  logic              i_ready
);

    typedef enum logic [3:0] {
        S_IDLE, S_RDIV, S_NORM, S_SQ, S_DIFF, S_LN,
        S_TMUL, S_KSTART, S_KDIV, S_FIN, S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic [R_W-1:0]    r_r, n_r;
    logic [2:0]        r_band, n_band;
    logic [5:0]        r_p, n_p;
    logic [31:0]       r_m, n_m;
    logic [31:0]       r_frac, n_frac;
    logic [4:0]        r_i, n_i;
    logic              r_neg, n_neg;
    logic [MAG_W-1:0]  r_mag, n_mag;
    logic [MAG_W-1:0]  r_ln, n_ln;
    logic [TP_W-1:0]   r_tp, n_tp;
    logic [TM_W-1:0]   r_tmag, n_tmag;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_ovalid, n_ovalid;
    logic [CODE_W-1:0] r_ocode, n_ocode;

    logic [63:0]       sq;
    logic [LOG_W-1:0]  diff;
    logic [LOG_W-1:0]  absd;
    logic [63:0]       prod;
    logic [29:0]       p_hi;
    logic [OFS_W-1:0]  sum;
    logic [OFS_W-1:0]  dif;
    logic [R_W-1:0]    rq;

    assign sq   = 64'(r_m) * 64'(r_m);
    assign diff = {2'b00, r_p, r_frac} - band_la(r_band);
    assign absd = diff[LOG_W-1] ? (~diff + 1'b1) : diff;
    assign p_hi = 30'(r_mag[33:32]) * 30'(LN2_Q28);
    assign prod = (64'(r_mag[31:0]) * 64'(LN2_Q28)) + {2'b00, p_hi, 32'd0};
    assign sum  = OFS_Q28 + {1'b0, r_tmag};
    assign dif  = OFS_Q28 - {1'b0, r_tmag};
    assign rq   = i_div_rsp.quotient[R_W-1:0];

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_ovalid;
    assign o_code  = r_ocode;

    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = {{(DIVN_W-NUM_W){1'b0}}, i_q_item.num};
        o_div_req.divisor  = i_q_item.den;
        if (r_state == S_IDLE && i_q_valid && i_q_item.kind == K_NORMAL)
            o_div_req.start = 1'b1;
        if (r_state == S_KSTART) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = {1'b0, r_tp};
            o_div_req.divisor  = band_k(r_band);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_r      = r_r;
        n_band   = r_band;
        n_p      = r_p;
        n_m      = r_m;
        n_frac   = r_frac;
        n_i      = r_i;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_ln     = r_ln;
        n_tp     = r_tp;
        n_tmag   = r_tmag;
        n_code   = r_code;
        n_ovalid = r_ovalid && !i_ready;
        n_ocode  = r_ocode;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.kind)
                        K_ZERO: begin
                            n_code  = CODE_MAX;
                            n_state = S_OUT;
                        end
                        K_FULL: begin
                            n_code  = '0;
                            n_state = S_OUT;
                        end
                        default: n_state = S_RDIV;
                    endcase
                end
            end
            S_RDIV: begin
                if (i_div_rsp.done) begin
                    if (rq >= R_COLD) begin
                        n_code  = '0;
                        n_state = S_OUT;
                    end else begin
                        n_r     = rq;
                        n_band  = band_of(rq);
                        n_p     = 6'd33;
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (r_r[R_W-1]) begin
                    n_m     = r_r[R_W-1:2];
                    n_frac  = '0;
                    n_i     = 5'd31;
                    n_state = S_SQ;
                end else begin
                    n_r = {r_r[R_W-2:0], 1'b0};
                    n_p = r_p - 1'b1;
                end
            end
            S_SQ: begin
                if (sq[63]) begin
                    n_m         = sq[63:32];
                    n_frac[r_i] = 1'b1;
                end else begin
                    n_m = sq[62:31];
                end
                if (r_i == '0)
                    n_state = S_DIFF;
                else
                    n_i = r_i - 1'b1;
            end
            S_DIFF: begin
                n_neg   = diff[LOG_W-1];
                n_mag   = absd[37:4];
                n_state = S_LN;
            end
            S_LN: begin
                n_ln    = prod[61:28];
                n_state = S_TMUL;
            end
            S_TMUL: begin
                n_tp    = TP_W'(r_ln) * TP_W'(T_SCALE);
                n_state = S_KSTART;
            end
            S_KSTART: n_state = S_KDIV;
            S_KDIV: begin
                if (i_div_rsp.done) begin
                    n_tmag  = i_div_rsp.quotient[TM_W-1:0];
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_neg) begin
                    if (sum[OFS_W-1:28] >= 21'(CODE_MAX))
                        n_code = CODE_MAX;
                    else
                        n_code = sum[42:28];
                end else if ({1'b0, r_tmag} >= OFS_Q28) begin
                    n_code = '0;
                end else begin
                    n_code = dif[42:28];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ocode  = r_code;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_r     <= n_r;
        r_band  <= n_band;
        r_p     <= n_p;
        r_m     <= n_m;
        r_frac  <= n_frac;
        r_i     <= n_i;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_ln    <= n_ln;
        r_tp    <= n_tp;
        r_tmag  <= n_tmag;
        r_code  <= n_code;
        r_ocode <= n_ocode;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== design/ntc_voltage_to_temperature_core.sv =====
// ----------------------------------------------------------------------------
// NTC voltage to temperature core
// Divider voltage in mV to temperature code (0.01 degC + 40 degC offset).
// ----------------------------------------------------------------------------
// The back end converts one item at a time, through two 52-step divider passes,
//   normalisation and the 32-step log2 loop; a resistance past the cold limit
//   ends after the first divider pass, and zero or full scale skip the divider.
// The queue takes new items while the back end works or a result waits.
// Reset: synchronous active-low i_rst_n empties queue, sequencer and output.
`include "ntc_voltage_to_temperature_core_assert.svh"

module ntc_voltage_to_temperature_core import ntcv2t_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntcv2t_in_if.sink     i_in,
    ntcv2t_out_if.source  o_out
);

    logic      q_ready;
    logic      q_push;
    t_item     f_item;
    logic      q_pop;
    logic      q_valid;
    t_item     q_item;
    t_q_status q_status;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    ntcv2t_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_item    (f_item)
    );

    ntcv2t_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (f_item),
        .o_ready  (q_ready),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_item   (q_item),
        .o_status (q_status)
    );

    ntcv2t_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ntcv2t_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_valid   (o_out.valid),
        .o_code    (o_out.temp_code),
        .i_ready   (o_out.ready)
    );

    `NTC_ASSERT_IMPL(a_code_range, o_out.valid, o_out.temp_code <= CODE_MAX, "code out of range")
    `NTC_ASSERT_IMPL(a_full_stall, q_status.full, !i_in.ready, "ready while queue full")
    `NTC_ASSERT_NEXT(a_div_pulse, div_rsp.done, !div_rsp.done && !div_rsp.busy, "divider done")

endmodule
